@@ rtl/vdid_pkg.sv @@
`default_nettype none

package vdid_pkg;

    localparam int unsigned VALUE_W    = 64;
    localparam int unsigned FREQ_W     = 63;
    localparam int unsigned GROUP_BITS = 7;
    localparam int unsigned CNT_W      = 4;
    localparam logic [CNT_W-1:0] MAX_BYTES = 4'd10;

    localparam logic [VALUE_W-1:0] MIN_RESET = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [VALUE_W-1:0] MAX_RESET = 64'h8000_0000_0000_0000;

    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // Position of the next varint inside a term-dictionary tuple
    typedef enum logic [1:0] {
        PH_TERM   = 2'd0,
        PH_OFFSET = 2'd1,
        PH_FREQ   = 2'd2
    } phase_t;

    // One event from the byte assembler to the accumulator
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               complete;
        logic               new_list;
        logic               clear_stats;
        logic               ovl;
    } event_t;

    // One step from the accumulator to the tracker and output stage
    typedef struct packed {
        logic [VALUE_W-1:0] main_val;
        logic [VALUE_W-1:0] offset_val;
        logic [FREQ_W-1:0]  freq;
        logic               emit;
        logic               clear_stats;
        logic               ovl;
    } step_t;

endpackage

`default_nettype wire

@@ rtl/vdid_front.sv @@
`default_nettype none

module vdid_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire logic [7:0]      byte_in,
    input  wire logic            new_list,
    input  wire logic            clear_stats,
    output logic                 push_valid,
    input  wire logic            push_ready,
    output vdid_pkg::event_t     push_data
);
    import vdid_pkg::*;

    logic [VALUE_W-1:0] part_reg, part_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [VALUE_W-1:0] part_base;
    logic [CNT_W-1:0]   count_base;
    logic [VALUE_W-1:0] part_new;
    logic [6:0]         shift_amt;
    logic               in_range;
    logic               complete;
    logic               accept;

    assign in_ready = push_ready;
    assign accept   = in_valid && in_ready;
    assign complete = !byte_in[7];

    always_comb
    begin
        part_base  = new_list ? '0 : part_reg;
        count_base = new_list ? '0 : count_reg;
        in_range   = count_base < MAX_BYTES;
        shift_amt  = 7'(count_base * GROUP_BITS);
        part_new   = part_base;
        if (in_range)
        begin
            part_new = part_base | (VALUE_W'(byte_in[6:0]) << shift_amt);
        end
        part_next  = part_reg;
        count_next = count_reg;
        if (accept)
        begin
            if (complete)
            begin
                part_next  = '0;
                count_next = '0;
            end
            else
            begin
                part_next  = part_new;
                count_next = in_range ? count_base + 1'b1 : count_base;
            end
        end
    end

    // Forward only bytes that matter to the back end
    assign push_valid            = accept && (complete || new_list || clear_stats || !in_range);
    assign push_data.value       = part_new;
    assign push_data.complete    = complete;
    assign push_data.new_list    = new_list;
    assign push_data.clear_stats = clear_stats;
    assign push_data.ovl         = !in_range;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            part_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            part_reg  <= part_next;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/vdid_fifo.sv @@
`default_nettype none

module vdid_fifo (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push_valid,
    output logic                  push_ready,
    input  wire vdid_pkg::event_t push_data,
    output logic                  pop_valid,
    input  wire logic             pop_ready,
    output vdid_pkg::event_t      pop_data
);
    import vdid_pkg::*;

    event_t                mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0] count_reg, count_next;
    logic                  do_push;
    logic                  do_pop;

    assign push_ready = count_reg != FIFO_CNT_W'(FIFO_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/vdid_accum.sv @@
`default_nettype none

module vdid_accum (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_write_en,
    input  wire logic             cfg_write_data,
    input  wire logic             ev_valid,
    output logic                  ev_ready,
    input  wire vdid_pkg::event_t ev_data,
    output logic                  st_valid,
    input  wire logic             st_ready,
    output vdid_pkg::step_t       st_data
);
    import vdid_pkg::*;

    logic               mode_reg;
    logic [VALUE_W-1:0] term_reg, term_next;
    logic [VALUE_W-1:0] offset_reg, offset_next;
    logic [VALUE_W-1:0] docid_reg, docid_next;
    phase_t             phase_reg, phase_next;
    logic               mark_reg, mark_next;
    logic               st_valid_reg, st_valid_next;
    step_t              st_reg, st_next;
    logic [VALUE_W-1:0] term_base, offset_base, docid_base;
    phase_t             phase_base;
    logic               mark_base;
    logic               pop;

    assign ev_ready = !st_valid_reg || st_ready;
    assign pop      = ev_valid && ev_ready;
    assign st_valid = st_valid_reg;
    assign st_data  = st_reg;

    always_comb
    begin
        term_base   = ev_data.new_list ? '0 : term_reg;
        offset_base = ev_data.new_list ? '0 : offset_reg;
        docid_base  = ev_data.new_list ? '0 : docid_reg;
        phase_base  = ev_data.new_list ? PH_TERM : phase_reg;
        mark_base   = (ev_data.new_list ? 1'b0 : mark_reg) | ev_data.ovl;

        term_next   = term_base;
        offset_next = offset_base;
        docid_next  = docid_base;
        phase_next  = phase_base;
        mark_next   = mark_base;

        st_next             = st_reg;
        st_next.emit        = 1'b0;
        st_next.clear_stats = ev_data.clear_stats;
        st_next.ovl         = mark_base;

        if (ev_data.complete)
        begin
            if (mode_reg)
            begin
                docid_next         = docid_base + ev_data.value;
                st_next.emit       = 1'b1;
                st_next.main_val   = docid_next;
                st_next.offset_val = '0;
                st_next.freq       = '0;
            end
            else
            begin
                unique case (phase_base)
                    PH_OFFSET:
                    begin
                        offset_next = offset_base + ev_data.value;
                        phase_next  = PH_FREQ;
                    end
                    PH_FREQ:
                    begin
                        phase_next         = PH_TERM;
                        st_next.emit       = 1'b1;
                        st_next.main_val   = term_base;
                        st_next.offset_val = offset_base;
                        st_next.freq       = ev_data.value[FREQ_W-1:0];
                    end
                    default:
                    begin
                        term_next  = term_base + ev_data.value;
                        phase_next = PH_OFFSET;
                    end
                endcase
            end
        end
        // Drop the overlong mark once a result carries it
        if (st_next.emit)
        begin
            mark_next = 1'b0;
        end

        st_valid_next = st_valid_reg;
        if (pop)
        begin
            st_valid_next = 1'b1;
        end
        else if (st_ready)
        begin
            st_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            st_reg <= st_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= 1'b0;
            term_reg     <= '0;
            offset_reg   <= '0;
            docid_reg    <= '0;
            phase_reg    <= PH_TERM;
            mark_reg     <= 1'b0;
            st_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                mode_reg <= cfg_write_data;
            end
            if (pop)
            begin
                term_reg   <= term_next;
                offset_reg <= offset_next;
                docid_reg  <= docid_next;
                phase_reg  <= phase_next;
                mark_reg   <= mark_next;
            end
            st_valid_reg <= st_valid_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/vdid_emit.sv @@
`default_nettype none

module vdid_emit (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        st_valid,
    output logic                             st_ready,
    input  wire vdid_pkg::step_t             st_data,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic signed [vdid_pkg::VALUE_W-1:0] value_main,
    output logic signed [vdid_pkg::VALUE_W-1:0] value_offset,
    output logic [vdid_pkg::FREQ_W-1:0]         doc_count,
    output logic signed [vdid_pkg::VALUE_W-1:0] low_seen,
    output logic signed [vdid_pkg::VALUE_W-1:0] high_seen,
    output logic [vdid_pkg::FREQ_W-1:0]         peak_freq,
    output logic                             overlong
);
    import vdid_pkg::*;

    logic signed [VALUE_W-1:0] min_reg, min_next;
    logic signed [VALUE_W-1:0] max_reg, max_next;
    logic [FREQ_W-1:0]         peak_reg, peak_next;
    logic signed [VALUE_W-1:0] min_base, max_base, main_s;
    logic [FREQ_W-1:0]         peak_base;
    logic                      out_valid_reg, out_valid_next;
    logic                      take;
    logic                      load;

    logic signed [VALUE_W-1:0] main_out_reg, offset_out_reg, low_out_reg, high_out_reg;
    logic [FREQ_W-1:0]         freq_out_reg, peak_out_reg;
    logic                      ovl_out_reg;

    // A step with no result never waits for the output register
    assign st_ready = !st_data.emit || !out_valid_reg || out_ready;
    assign take     = st_valid && st_ready;
    assign load     = take && st_data.emit;

    always_comb
    begin
        main_s    = $signed(st_data.main_val);
        min_base  = st_data.clear_stats ? $signed(MIN_RESET) : min_reg;
        max_base  = st_data.clear_stats ? $signed(MAX_RESET) : max_reg;
        peak_base = st_data.clear_stats ? '0 : peak_reg;
        min_next  = min_base;
        max_next  = max_base;
        peak_next = peak_base;
        if (st_data.emit)
        begin
            if (main_s < min_base)
            begin
                min_next = main_s;
            end
            if (max_base < main_s)
            begin
                max_next = main_s;
            end
            if (st_data.freq > peak_base)
            begin
                peak_next = st_data.freq;
            end
        end

        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            main_out_reg   <= main_s;
            offset_out_reg <= $signed(st_data.offset_val);
            freq_out_reg   <= st_data.freq;
            low_out_reg    <= min_next;
            high_out_reg   <= max_next;
            peak_out_reg   <= peak_next;
            ovl_out_reg    <= st_data.ovl;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg       <= $signed(MIN_RESET);
            max_reg       <= $signed(MAX_RESET);
            peak_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                min_reg  <= min_next;
                max_reg  <= max_next;
                peak_reg <= peak_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign value_main   = main_out_reg;
    assign value_offset = offset_out_reg;
    assign doc_count    = freq_out_reg;
    assign low_seen     = low_out_reg;
    assign high_seen    = high_out_reg;
    assign peak_freq    = peak_out_reg;
    assign overlong     = ovl_out_reg;

endmodule

`default_nettype wire

@@ rtl/varint_delta_index_decoder_top.sv @@
// Channel  Handshake               Payload
// in       in_valid / in_ready     byte_in, new_list, clear_stats
// out      out_valid / out_ready   value_main, value_offset, doc_count, low_seen,
//                                  high_seen, peak_freq, overlong
// cfg      cfg_write_en            cfg_write_data (stream_mode)
//
// One byte per cycle sustained while the event queue is not full; the byte that
// completes a result passes the event queue, sum stage and tracker/output register.
// The rate is set by the 64-bit sum add and the min/max compares, one per stage.
// in_ready drops only when the four-entry event queue is full.
// Reset is asynchronous; all trackers and sums are usable the cycle after release.
`default_nettype none

module varint_delta_index_decoder_top (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_write_en,
    input  wire logic                        cfg_write_data,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [7:0]                  byte_in,
    input  wire logic                        new_list,
    input  wire logic                        clear_stats,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic signed [vdid_pkg::VALUE_W-1:0] value_main,
    output logic signed [vdid_pkg::VALUE_W-1:0] value_offset,
    output logic [vdid_pkg::FREQ_W-1:0]         doc_count,
    output logic signed [vdid_pkg::VALUE_W-1:0] low_seen,
    output logic signed [vdid_pkg::VALUE_W-1:0] high_seen,
    output logic [vdid_pkg::FREQ_W-1:0]         peak_freq,
    output logic                             overlong
);
    import vdid_pkg::*;

    logic   push_valid, push_ready;
    event_t push_data;
    logic   ev_valid, ev_ready;
    event_t ev_data;
    logic   st_valid, st_ready;
    step_t  st_data;

    vdid_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .byte_in     (byte_in),
        .new_list    (new_list),
        .clear_stats (clear_stats),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_data   (push_data)
    );

    vdid_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (ev_valid),
        .pop_ready  (ev_ready),
        .pop_data   (ev_data)
    );

    vdid_accum u_accum (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .ev_valid       (ev_valid),
        .ev_ready       (ev_ready),
        .ev_data        (ev_data),
        .st_valid       (st_valid),
        .st_ready       (st_ready),
        .st_data        (st_data)
    );

    vdid_emit u_emit (
        .clk          (clk),
        .rst_n        (rst_n),
        .st_valid     (st_valid),
        .st_ready     (st_ready),
        .st_data      (st_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .value_main   (value_main),
        .value_offset (value_offset),
        .doc_count    (doc_count),
        .low_seen     (low_seen),
        .high_seen    (high_seen),
        .peak_freq    (peak_freq),
        .overlong     (overlong)
    );

    a_main_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (low_seen <= value_main) && (value_main <= high_seen))
        else $error("value_main outside tracked range");

    a_peak_covers_freq: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> peak_freq >= doc_count)
        else $error("peak_freq below doc_count");

    a_step_drains: assert property (@(posedge clk) disable iff (!rst_n)
        st_valid && !st_data.emit |-> st_ready)
        else $error("step without result stalled");

endmodule

`default_nettype wire
